@@ design/grid_strict_local_max_marker_core_assert.svh @@
// Assertion macros shared by the grid local maximum marker modules.
`ifndef GRID_STRICT_LOCAL_MAX_MARKER_CORE_ASSERT_SVH
`define GRID_STRICT_LOCAL_MAX_MARKER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a condition at every clock edge out of reset.
`define GLM_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("glm check failed");
// Check that a condition holds in the cycle after a trigger.
`define GLM_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("glm sequence check failed");
`else
`define GLM_ASSERT(label, cond)
`define GLM_ASSERT_NEXT(label, pre, post)
`endif
`endif

@@ design/glm_pkg.sv @@
// Types, constants and helpers shared by the grid local maximum marker.
`default_nettype none
package glm_pkg;

  localparam int unsigned GLM_MAX_SIDE = 128;
  localparam int unsigned GLM_DW       = 4;
  localparam int unsigned GLM_RQ_DEPTH = 4;
  localparam logic [7:0]  GLM_SIDE_RST = 8'd8;

  // One result item
  typedef struct packed {
    logic [GLM_DW-1:0] depth;
    logic              cav;
    logic              last;
  } res_t;

  // Up to two result items pushed at once; the second only with the first
  typedef struct packed {
    logic v0;
    logic v1;
    res_t d0;
    res_t d1;
  } rq_wr_t;

  // Per-cell control of the line chain
  typedef struct packed {
    logic shift;
    logic tail;
  } cell_ctl_t;

  // Clamp the configured side into 1..max_side and return side minus one
  function automatic int unsigned glm_side_m1(logic [7:0] side, int unsigned max_side);
    int unsigned s;
    s = int'(side);
    if (s == 0) return 0;
    if (s > max_side) return max_side - 1;
    return s - 1;
  endfunction

endpackage
`default_nettype wire

@@ design/grid_strict_local_max_marker_core.sv @@
// A result item enters the result queue at the edge that accepts its item and is offered once the items ahead go.
// One item per cycle while the result queue has room; in the grid's last row each item yields two results,
// so the single output port holds the input back there.
// The line chain shifts one cell per accepted item; no clearing pass follows reset.
// Reset clears position, window and queue, and sets the side to eight.
`default_nettype none
module grid_strict_local_max_marker_core
  import glm_pkg::*;
#(
  parameter int unsigned MAX_SIDE = GLM_MAX_SIDE
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_grid_side,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [GLM_DW-1:0] in_depth_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [GLM_DW-1:0] out_depth_out,
  output logic                   out_is_cavity,
  output logic                   out_last
);

  localparam int unsigned CW = $clog2(MAX_SIDE);
  localparam int unsigned EW = 2 * GLM_DW;

  logic [CW-1:0]     side_m1_r, side_m1_nxt;
  logic [CW-1:0]     row_count_r, row_count_nxt;
  logic [CW-1:0]     col_count_r, col_count_nxt;
  logic [GLM_DW-1:0] window_r, window_nxt;

  logic [EW-1:0]     cell_q [MAX_SIDE];
  logic [EW-1:0]     ins_d;
  logic              accept;
  logic              room;
  logic              final_row, final_col, interior, cav;
  logic [GLM_DW-1:0] center, up, right;
  rq_wr_t            wr;
  res_t              out_d;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = !room;

  // Neighbours: cell 0 holds this column, cell 1 the next one
  assign center    = cell_q[0][GLM_DW-1:0];
  assign up        = cell_q[0][EW-1:GLM_DW];
  assign right     = cell_q[1][GLM_DW-1:0];
  assign final_row = (row_count_r == side_m1_r);
  assign final_col = (col_count_r == side_m1_r);
  assign interior  = (row_count_r >= CW'(2)) && (col_count_r != '0) && !final_col;
  assign cav       = interior && (center > up) && (center > in_depth_in)
                     && (center > window_r) && (center > right);
  assign ins_d     = {center, in_depth_in};

  // Line chain: every cell shifts on accept, the new entry lands at the side's tail
  for (genvar i = 0; i < MAX_SIDE; i++) begin : g_cell
    cell_ctl_t     ctl;
    logic [EW-1:0] next_d;
    assign ctl.shift = accept;
    assign ctl.tail  = (side_m1_r == CW'(i));
    if (i == MAX_SIDE - 1) begin : g_end
      assign next_d = ins_d;
    end else begin : g_mid
      assign next_d = cell_q[i+1];
    end
    glm_cell #(.W(EW)) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .ins_d  (ins_d),
      .next_d (next_d),
      .q      (cell_q[i])
    );
  end

  // Build the result items: lagged row first, then the last-row border item
  always_comb begin
    wr          = '0;
    wr.d0.depth = center;
    wr.d0.cav   = cav;
    wr.d0.last  = 1'b0;
    wr.d1.depth = in_depth_in;
    wr.d1.cav   = 1'b0;
    wr.d1.last  = final_col;
    if (accept) begin
      if (row_count_r != '0) begin
        wr.v0 = 1'b1;
        wr.v1 = final_row;
      end else if (final_row) begin
        wr.v0 = 1'b1;
        wr.d0 = wr.d1;
      end
    end
  end

  // Advance position and window; a configuration write restarts the grid
  always_comb begin
    side_m1_nxt   = side_m1_r;
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    window_nxt    = window_r;
    if (cfg_we) begin
      side_m1_nxt   = CW'(glm_side_m1(cfg_grid_side, MAX_SIDE));
      row_count_nxt = '0;
      col_count_nxt = '0;
      window_nxt    = '0;
    end else if (accept) begin
      if (final_col) begin
        col_count_nxt = '0;
        window_nxt    = '0;
        row_count_nxt = final_row ? '0 : row_count_r + CW'(1);
      end else begin
        col_count_nxt = col_count_r + CW'(1);
        window_nxt    = center;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_m1_r   <= CW'(glm_side_m1(GLM_SIDE_RST, MAX_SIDE));
      row_count_r <= '0;
      col_count_r <= '0;
      window_r    <= '0;
    end else begin
      side_m1_r   <= side_m1_nxt;
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      window_r    <= window_nxt;
    end
  end

  // Hold results until the consumer takes them
  glm_rq #(.DEPTH(GLM_RQ_DEPTH)) u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_d     (out_d)
  );

  assign out_depth_out = out_d.depth;
  assign out_is_cavity = out_d.cav;
  assign out_last      = out_d.last;

`include "grid_strict_local_max_marker_core_assert.svh"
  `GLM_ASSERT(a_pos_bound, (col_count_r <= side_m1_r) && (row_count_r <= side_m1_r))
  `GLM_ASSERT(a_last_is_border, !(out_valid && out_is_cavity && out_last))
  `GLM_ASSERT_NEXT(a_cfg_restart, cfg_we, (col_count_r == '0) && (row_count_r == '0))

endmodule
`default_nettype wire

@@ design/glm_cell.sv @@
// One cell of the line chain: holds a column's two stored digits.
`default_nettype none
module glm_cell
  import glm_pkg::*;
#(
  parameter int unsigned W = 2 * GLM_DW
) (
  input  wire logic         clk,
  input  wire cell_ctl_t    ctl,
  input  wire logic [W-1:0] ins_d,
  input  wire logic [W-1:0] next_d,
  output logic      [W-1:0] q
);

  logic [W-1:0] q_r;
  logic [W-1:0] q_nxt;

  // Advance from the neighbour, or take the new entry at the tail cell
  always_comb begin
    q_nxt = q_r;
    if (ctl.shift) begin
      q_nxt = ctl.tail ? ins_d : next_d;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
`default_nettype wire

@@ design/glm_rq.sv @@
// Result queue: takes up to two result items a cycle, hands out one.
`default_nettype none
module glm_rq
  import glm_pkg::*;
#(
  parameter int unsigned DEPTH = GLM_RQ_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire rq_wr_t wr,
  output logic        room,
  output logic        out_valid,
  input  wire logic   out_stall,
  output res_t        out_d
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  res_t            mem_r   [DEPTH];
  res_t            mem_nxt [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]   wr_ptr_p1;
  logic            pop;

  assign wr_ptr_p1 = wr_ptr_r + AW'(1);
  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_d     = mem_r[rd_ptr_r];
  assign room      = (cnt_r <= CNTW'(DEPTH - 2));

  // Write the first item at the write pointer, the second just after it
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      mem_nxt[j] = mem_r[j];
      if (wr.v0 && (wr_ptr_r == AW'(j))) begin
        mem_nxt[j] = wr.d0;
      end else if (wr.v1 && (wr_ptr_p1 == AW'(j))) begin
        mem_nxt[j] = wr.d1;
      end
    end
  end

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(wr.v0) + AW'(wr.v1);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    cnt_nxt    = cnt_r + CNTW'(wr.v0) + CNTW'(wr.v1) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DEPTH; j++) begin
      mem_r[j] <= mem_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`include "grid_strict_local_max_marker_core_assert.svh"
  `GLM_ASSERT(a_rq_cnt_bound, cnt_r <= CNTW'(DEPTH))
  `GLM_ASSERT(a_rq_push_room, !wr.v0 || room)
  `GLM_ASSERT(a_rq_pair_order, !wr.v1 || wr.v0)

endmodule
`default_nettype wire
